FILE: rtl/aisnf_pkg.sv
// Shared types, constants and character functions for the AIVDM sentence framer.
`timescale 1ns / 1ps
`default_nettype none

package aisnf_pkg;

  localparam int FRAGMENT_CHARS_DEF = 61;
  localparam int QUEUE_DEPTH = 2;
  localparam int HDR_LEN = 14;

  localparam logic [6:0] PAYLOAD_SYMBOLS_RST = 7'd71;

  localparam logic [6:0] CH_COMMA = 7'h2C;
  localparam logic [6:0] CH_ZERO = 7'h30;
  localparam logic [6:0] CH_STAR = 7'h2A;
  localparam logic [6:0] CH_NL = 7'h0A;

  typedef enum logic [1:0] {
    HDR_SINGLE,
    HDR_FIRST,
    HDR_SECOND
  } hdr_sel_t;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_SYM,
    PH_COMMA,
    PH_ZERO,
    PH_STAR,
    PH_HI,
    PH_LO,
    PH_NL
  } phase_t;

  // One classified item, handed from the front to the back.
  typedef struct packed {
    logic       hdr_en;
    hdr_sel_t   hdr_sel;
    logic [6:0] sym_char;
    logic       close;
    logic       newline;
    logic [6:0] sum;
  } cmd_t;

  // Character idx of the header "!AIVDM,n,k,,A,".
  function automatic logic [6:0] hdr_char(input hdr_sel_t sel, input logic [3:0] idx);
    logic [6:0] c;
    case (idx)
      4'd0:    c = 7'h21;
      4'd1:    c = 7'h41;
      4'd2:    c = 7'h49;
      4'd3:    c = 7'h56;
      4'd4:    c = 7'h44;
      4'd5:    c = 7'h4D;
      4'd7:    c = (sel == HDR_SINGLE) ? 7'h31 : 7'h32;
      4'd9:    c = (sel == HDR_SECOND) ? 7'h32 : 7'h31;
      4'd12:   c = 7'h41;
      default: c = CH_COMMA;
    endcase
    return c;
  endfunction

  // Checksum of the header characters after '!'.
  function automatic logic [6:0] hdr_xor(input hdr_sel_t sel);
    logic [6:0] x;
    x = 7'd0;
    for (int i = 1; i < HDR_LEN; i++) begin
      x = x ^ hdr_char(sel, 4'(i));
    end
    return x;
  endfunction

  function automatic logic [6:0] armor(input logic [5:0] v);
    return (v < 6'd40) ? ({1'b0, v} + 7'd48) : ({1'b0, v} + 7'd56);
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? ({3'd0, n} + 7'h30) : ({3'd0, n} + 7'h37);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/aisnf_front.sv
// Front end: length register, fragment tracking and checksum, one command per item.
`timescale 1ns / 1ps
`default_nettype none

module aisnf_front #(
  parameter int FRAGMENT_CHARS = aisnf_pkg::FRAGMENT_CHARS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [6:0]       cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [5:0]       symbol,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output aisnf_pkg::cmd_t       cmd
);

  localparam logic [6:0] FC = 7'(FRAGMENT_CHARS);
  localparam logic [6:0] FC2 = 7'(2 * FRAGMENT_CHARS);

  logic [6:0] payload_symbols;
  logic [6:0] symbol_count;
  logic [6:0] running_xor;
  logic       fragment_index;

  logic [6:0] len;
  logic       two;
  logic [6:0] frag_len;
  logic [6:0] count_next;
  logic [6:0] xor_base;
  logic [6:0] xor_after;
  logic       accept;
  aisnf_pkg::hdr_sel_t sel;

  assign cfg_ready = 1'b1;
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  always_comb begin
    if (payload_symbols == 7'd0) begin
      len = 7'd1;
    end else if (payload_symbols > FC2) begin
      len = FC2;
    end else begin
      len = payload_symbols;
    end
    two = len > FC;
    if (!fragment_index) begin
      frag_len = two ? FC : len;
    end else begin
      frag_len = two ? (len - FC) : 7'd0;
    end
    if (fragment_index) begin
      sel = aisnf_pkg::HDR_SECOND;
    end else if (two) begin
      sel = aisnf_pkg::HDR_FIRST;
    end else begin
      sel = aisnf_pkg::HDR_SINGLE;
    end
    count_next = symbol_count + 7'd1;
    xor_base   = (symbol_count == 7'd0) ? aisnf_pkg::hdr_xor(sel) : running_xor;
    cmd.hdr_en   = (symbol_count == 7'd0);
    cmd.hdr_sel  = sel;
    cmd.sym_char = aisnf_pkg::armor(symbol);
    xor_after    = xor_base ^ cmd.sym_char;
    cmd.close    = count_next >= frag_len;
    cmd.newline  = cmd.close && !fragment_index && two;
    cmd.sum      = xor_after ^ aisnf_pkg::CH_COMMA ^ aisnf_pkg::CH_ZERO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_symbols <= aisnf_pkg::PAYLOAD_SYMBOLS_RST;
      symbol_count    <= 7'd0;
      running_xor     <= 7'd0;
      fragment_index  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        payload_symbols <= cfg_data;
      end
      if (accept) begin
        if (cmd.close) begin
          symbol_count   <= 7'd0;
          running_xor    <= 7'd0;
          fragment_index <= cmd.newline;
        end else begin
          symbol_count <= count_next;
          running_xor  <= xor_after;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/aisnf_queue.sv
// Small command queue between the front end and the character sequencer.
`timescale 1ns / 1ps
`default_nettype none

module aisnf_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire aisnf_pkg::cmd_t push_cmd,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output aisnf_pkg::cmd_t      pop_cmd
);

  localparam int D = aisnf_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  aisnf_pkg::cmd_t entries [D];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = count != CW'(D);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(D - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(D - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/aisnf_back.sv
// Back end: expands a command into its symbol, any header and trailer.
`timescale 1ns / 1ps
`default_nettype none

module aisnf_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire aisnf_pkg::cmd_t cmd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [6:0]           out_char,
  output logic                 run_last
);

  aisnf_pkg::phase_t phase;
  aisnf_pkg::phase_t phase_next;
  aisnf_pkg::cmd_t   cur;
  logic              busy;
  logic              busy_next;
  logic [3:0]        hidx;
  logic [3:0]        hidx_next;
  logic              step;
  logic              pop;
  logic [6:0]        ch;
  logic              last;

  assign step      = busy && (!out_valid || out_ready);
  assign pop       = cmd_valid && (!busy || (step && last));
  assign cmd_ready = pop;

  // Character generation
  always_comb begin
    ch   = aisnf_pkg::CH_NL;
    last = 1'b1;
    case (phase)
      aisnf_pkg::PH_HDR: begin
        ch   = aisnf_pkg::hdr_char(cur.hdr_sel, hidx);
        last = 1'b0;
      end
      aisnf_pkg::PH_SYM: begin
        ch   = cur.sym_char;
        last = !cur.close;
      end
      aisnf_pkg::PH_COMMA: begin
        ch   = aisnf_pkg::CH_COMMA;
        last = 1'b0;
      end
      aisnf_pkg::PH_ZERO: begin
        ch   = aisnf_pkg::CH_ZERO;
        last = 1'b0;
      end
      aisnf_pkg::PH_STAR: begin
        ch   = aisnf_pkg::CH_STAR;
        last = 1'b0;
      end
      aisnf_pkg::PH_HI: begin
        ch   = aisnf_pkg::hex_char({1'b0, cur.sum[6:4]});
        last = 1'b0;
      end
      aisnf_pkg::PH_LO: begin
        ch   = aisnf_pkg::hex_char(cur.sum[3:0]);
        last = !cur.newline;
      end
      aisnf_pkg::PH_NL: begin
        ch   = aisnf_pkg::CH_NL;
        last = 1'b1;
      end
      default: begin
        ch   = aisnf_pkg::CH_NL;
        last = 1'b1;
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_next = phase;
    hidx_next  = hidx;
    busy_next  = busy;
    if (step) begin
      case (phase)
        aisnf_pkg::PH_HDR: begin
          hidx_next = hidx + 4'd1;
          if (hidx == 4'(aisnf_pkg::HDR_LEN - 1)) begin
            phase_next = aisnf_pkg::PH_SYM;
          end
        end
        aisnf_pkg::PH_SYM:   phase_next = aisnf_pkg::PH_COMMA;
        aisnf_pkg::PH_COMMA: phase_next = aisnf_pkg::PH_ZERO;
        aisnf_pkg::PH_ZERO:  phase_next = aisnf_pkg::PH_STAR;
        aisnf_pkg::PH_STAR:  phase_next = aisnf_pkg::PH_HI;
        aisnf_pkg::PH_HI:    phase_next = aisnf_pkg::PH_LO;
        aisnf_pkg::PH_LO:    phase_next = aisnf_pkg::PH_NL;
        default:             phase_next = aisnf_pkg::PH_NL;
      endcase
      if (last) begin
        busy_next = 1'b0;
      end
    end
    if (pop) begin
      busy_next  = 1'b1;
      hidx_next  = 4'd0;
      phase_next = cmd.hdr_en ? aisnf_pkg::PH_HDR : aisnf_pkg::PH_SYM;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= cmd;
    end
    if (step) begin
      out_char <= ch;
      run_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= aisnf_pkg::PH_HDR;
      hidx      <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      busy  <= busy_next;
      phase <= phase_next;
      hidx  <= hidx_next;
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ais_payload_nmea_framer_core.sv
// Top level of the AIS payload to !AIVDM sentence framer.
//
// Usage:
//   symbol/in_valid/in_ready: one 6-bit payload symbol per item.
//   out_char/run_last/out_valid/out_ready: one ASCII character per item;
//     run_last marks the final character produced by an input symbol.
//   cfg_data/cfg_valid/cfg_ready: payload length in symbols (write only
//     while idle); cfg_ready is always high.
// Path to the output: command queue, sequencer command register, output register.
// Throughput: one character per cycle from the back-end sequencer while the
//   output is not stalled, and a symbol yields 1 character, 15 with a header,
//   and 5 or 6 more when it closes a fragment (1 to 21 characters). A
//   2-entry command queue lets the front end accept new symbols while the
//   sequencer is still expanding.
// Reset: length 71, first fragment, empty checksum, queue and output empty.
// Stall: while out_ready is low the output register holds; the queue fills
//   and then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module ais_payload_nmea_framer_core #(
  parameter int FRAGMENT_CHARS = aisnf_pkg::FRAGMENT_CHARS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [6:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [5:0] symbol,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      out_char,
  output logic            run_last
);

  aisnf_pkg::cmd_t front_cmd;
  aisnf_pkg::cmd_t back_cmd;
  logic            front_valid;
  logic            front_ready;
  logic            back_valid;
  logic            back_ready;

  aisnf_front #(
    .FRAGMENT_CHARS(FRAGMENT_CHARS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .symbol    (symbol),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  aisnf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  aisnf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .run_last  (run_last)
  );

endmodule

`default_nettype wire
